[rtl/core/hrhc_pkg.sv]
package hrhc_pkg;

    // phase codes
    localparam logic [1:0] PH_REQ  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // request line field codes
    localparam logic [1:0] FP_METHOD  = 2'd0;
    localparam logic [1:0] FP_URI     = 2'd1;
    localparam logic [1:0] FP_VERSION = 2'd2;

    // action codes
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_CLOSE   = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;
    localparam logic [1:0] ACT_START   = 2'd3;

    // verdict codes
    localparam logic [2:0] V_OK      = 3'd0;
    localparam logic [2:0] V_BAD     = 3'd1;
    localparam logic [2:0] V_URI     = 3'd2;
    localparam logic [2:0] V_FIELDS  = 3'd3;
    localparam logic [2:0] V_TIMEOUT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_REQ_LINE = 2'd0;
    localparam logic [1:0] CFG_MAX_HDR_LINE = 2'd1;
    localparam logic [1:0] CFG_MAX_HDR_CNT  = 2'd2;

    localparam logic [15:0] CFG_RESET_VAL = 16'd1024;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] VER_LEN      = 4'd8;
    localparam logic [3:0] VER_POS_MAJ  = 4'd5;
    localparam logic [3:0] VER_POS_MIN  = 4'd7;
    localparam logic [7:0] VER_TEXT [8] = '{8'h48, 8'h54, 8'h54, 8'h50,
                                            8'h2F, 8'h30, 8'h2E, 8'h30};

    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  field_part;
        logic [15:0] line_length;
        logic        cr_pending;
        logic        line_bad;
        logic        method_nonempty;
        logic        target_nonempty;
        logic [3:0]  version_position;
        logic [3:0]  major_digit;
        logic [3:0]  minor_digit;
        logic        colon_seen;
        logic [15:0] header_lines;
    } t_hstate;

    localparam t_hstate ST_CLEAR = '{
        phase: PH_REQ, field_part: FP_METHOD, line_length: 16'd0,
        cr_pending: 1'b0, line_bad: 1'b0, method_nonempty: 1'b0,
        target_nonempty: 1'b0, version_position: 4'd0, major_digit: 4'd0,
        minor_digit: 4'd0, colon_seen: 1'b0, header_lines: 16'd0};

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_tchar(logic [7:0] b);
        logic alpha;
        alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
        return is_digit(b) || alpha ||
               b == 8'h21 || b == 8'h23 || b == 8'h24 || b == 8'h25 ||
               b == 8'h26 || b == 8'h27 || b == 8'h2A || b == 8'h2B ||
               b == 8'h2D || b == 8'h5E || b == 8'h5F || b == 8'h60 ||
               b == 8'h7C || b == 8'h7E;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SP) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic t_hstate clear_line(t_hstate s);
        t_hstate r;
        r                 = s;
        r.field_part      = FP_METHOD;
        r.line_length     = 16'd0;
        r.cr_pending      = 1'b0;
        r.line_bad        = 1'b0;
        r.method_nonempty = 1'b0;
        r.target_nonempty = 1'b0;
        r.colon_seen      = 1'b0;
        return r;
    endfunction

    // One content byte of the current line (CR/LF framing handled by caller).
    function automatic t_hstate take_content(t_hstate s, logic [7:0] b);
        t_hstate r;
        r = s;
        if (r.phase == PH_REQ) begin
            if (r.field_part == FP_METHOD) begin
                if (b == CH_SP) begin
                    if (!r.method_nonempty) r.line_bad = 1'b1;
                    r.field_part = FP_URI;
                end else begin
                    if (!is_tchar(b)) r.line_bad = 1'b1;
                    r.method_nonempty = 1'b1;
                end
            end else if (r.field_part == FP_URI) begin
                if (b == CH_SP) begin
                    if (!r.target_nonempty) r.line_bad = 1'b1;
                    r.field_part = FP_VERSION;
                end else begin
                    if (is_space(b)) r.line_bad = 1'b1;
                    r.target_nonempty = 1'b1;
                end
            end else if (r.version_position >= VER_LEN) begin
                r.line_bad = 1'b1;
            end else begin
                if (r.version_position == VER_POS_MAJ ||
                    r.version_position == VER_POS_MIN) begin
                    if (!is_digit(b)) r.line_bad = 1'b1;
                    else if (r.version_position == VER_POS_MAJ) r.major_digit = b[3:0];
                    else r.minor_digit = b[3:0];
                end else if (b != VER_TEXT[r.version_position[2:0]]) begin
                    r.line_bad = 1'b1;
                end
                r.version_position = r.version_position + 4'd1;
            end
        end else if (!r.colon_seen) begin
            if (b == CH_COLON) begin
                if (!r.method_nonempty) r.line_bad = 1'b1;
                r.colon_seen = 1'b1;
            end else begin
                if (!is_tchar(b)) r.line_bad = 1'b1;
                r.method_nonempty = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/hrhc_if.sv]
interface hrhc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface hrhc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic [15:0] header_count;

    modport source (output valid, output verdict, output version_major,
                    output version_minor, output header_count, input ready);
    modport sink (input valid, input verdict, input version_major,
                  input version_minor, input header_count, output ready);
endinterface

[rtl/core/http_request_head_checker.sv]
// HTTP request head checker. Feed the head one word per clock on i_req (action 0 with a
// data byte, 1 peer closed, 2 read timeout, 3 start a new request); at most one verdict
// per request comes out on o_res with the version digits and the header line count.
// The block takes one word every clock while o_res is not stalled: the word lands in an
// input register, one pass of byte-classification logic updates the line state, and a
// verdict lands in the output register that drives o_res. Throughput is set by that
// single pass; a stalled o_res holds the pipe and drops i_req.ready once both registers
// are full. Length and header-count limits are written on the cfg port, by the user
// only while no request is in flight; the block itself does not enforce it.
module http_request_head_checker
    import hrhc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata,
    hrhc_in_if.sink      i_req,
    hrhc_out_if.source   o_res
);

    logic [15:0] r_max_req_line;
    logic [15:0] r_max_hdr_line;
    logic [15:0] r_max_hdr_cnt;

    logic        r_in_valid;
    logic [1:0]  r_in_action;
    logic [7:0]  r_in_byte;

    t_hstate     r_st;
    t_hstate     n_st;

    logic        r_out_valid;
    logic [2:0]  r_verdict;
    logic [3:0]  r_ver_major;
    logic [3:0]  r_ver_minor;
    logic [15:0] r_hdr_count;

    logic        advance;
    logic        emit;
    logic [2:0]  n_verdict;
    logic [3:0]  n_ver_major;
    logic [3:0]  n_ver_minor;
    logic [15:0] n_hdr_count;
    logic [15:0] limit;
    logic [2:0]  over;

    assign advance     = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || advance;

    always_comb begin
        n_st        = r_st;
        emit        = 1'b0;
        n_verdict   = V_OK;
        limit       = (r_st.phase == PH_REQ) ? r_max_req_line : r_max_hdr_line;
        over        = (r_st.phase == PH_REQ) ? V_URI : V_FIELDS;

        if (r_in_action == ACT_START) begin
            n_st = ST_CLEAR;
        end else if (r_st.phase != PH_DONE) begin
            if (r_st.line_length >= limit) begin
                emit = 1'b1; n_verdict = over;
            end else if (r_in_action == ACT_CLOSE) begin
                emit = 1'b1; n_verdict = V_BAD;
            end else if (r_in_action == ACT_TIMEOUT) begin
                emit = 1'b1; n_verdict = V_TIMEOUT;
            end else if (r_in_byte == 8'h00) begin
                emit = 1'b1; n_verdict = V_BAD;
            end else begin
                n_st.line_length = r_st.line_length + 16'd1;
                if (r_st.cr_pending && r_in_byte == CH_LF) begin
                    // line complete
                    n_st.cr_pending = 1'b0;
                    if (r_st.phase == PH_REQ) begin
                        if (n_st.line_bad || n_st.field_part != FP_VERSION ||
                            n_st.version_position != VER_LEN) begin
                            emit = 1'b1; n_verdict = V_BAD;
                        end else begin
                            n_st       = clear_line(n_st);
                            n_st.phase = PH_HDR;
                        end
                    end else if (n_st.line_length == 16'd2) begin
                        emit = 1'b1; n_verdict = V_OK;
                    end else if (n_st.header_lines >= r_max_hdr_cnt) begin
                        emit = 1'b1; n_verdict = V_FIELDS;
                    end else if (n_st.line_bad || !n_st.colon_seen) begin
                        emit = 1'b1; n_verdict = V_BAD;
                    end else begin
                        n_st.header_lines = n_st.header_lines + 16'd1;
                        n_st = clear_line(n_st);
                    end
                end else begin
                    // a CR not followed by LF is ordinary content
                    if (r_st.cr_pending) begin
                        n_st            = take_content(n_st, CH_CR);
                        n_st.cr_pending = 1'b0;
                    end
                    if (r_in_byte == CH_CR) n_st.cr_pending = 1'b1;
                    else n_st = take_content(n_st, r_in_byte);
                    if (n_st.line_length >= limit) begin
                        emit = 1'b1; n_verdict = over;
                    end
                end
            end
        end

        n_ver_major = (n_verdict == V_OK) ? n_st.major_digit : 4'd0;
        n_ver_minor = (n_verdict == V_OK) ? n_st.minor_digit : 4'd0;
        n_hdr_count = n_st.header_lines;
        if (emit) n_st.phase = PH_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req_line <= CFG_RESET_VAL;
            r_max_hdr_line <= CFG_RESET_VAL;
            r_max_hdr_cnt  <= CFG_RESET_VAL;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_st           <= ST_CLEAR;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_REQ_LINE: r_max_req_line <= i_cfg_wdata;
                    CFG_MAX_HDR_LINE: r_max_hdr_line <= i_cfg_wdata;
                    CFG_MAX_HDR_CNT:  r_max_hdr_cnt  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && emit;
                if (r_in_valid) begin
                    r_st <= n_st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_action <= i_req.action;
            r_in_byte   <= i_req.data_byte;
        end
        if (advance && r_in_valid && emit) begin
            r_verdict   <= n_verdict;
            r_ver_major <= n_ver_major;
            r_ver_minor <= n_ver_minor;
            r_hdr_count <= n_hdr_count;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.verdict       = r_verdict;
    assign o_res.version_major = r_ver_major;
    assign o_res.version_minor = r_ver_minor;
    assign o_res.header_count  = r_hdr_count;

endmodule

[rtl/core/hrhc_checker.sv]
module hrhc_checker
    import hrhc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_verdict,
    input logic [3:0]  i_version_major,
    input logic [3:0]  i_version_minor,
    input logic [15:0] i_header_count
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_verdict) && $stable(i_version_major) &&
            $stable(i_version_minor) && $stable(i_header_count))
        else $error("result word changed while stalled");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_verdict == V_OK || i_verdict == V_BAD || i_verdict == V_URI ||
                         i_verdict == V_FIELDS || i_verdict == V_TIMEOUT))
        else $error("undefined verdict code");

    a_version_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict != V_OK |->
            i_version_major == 4'd0 && i_version_minor == 4'd0)
        else $error("version digits on a rejected request");

    a_version_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict == V_OK |->
            i_version_major <= 4'd9 && i_version_minor <= 4'd9)
        else $error("version digit out of range");

endmodule

bind http_request_head_checker hrhc_checker u_hrhc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_verdict       (o_res.verdict),
    .i_version_major (o_res.version_major),
    .i_version_minor (o_res.version_minor),
    .i_header_count  (o_res.header_count)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import hrhc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAJOR_POS      = 5;
    localparam int MINOR_POS      = 7;
    localparam int PROTO_LEN      = 8;
    // "HTTP/0.0", digit positions are checked separately
    localparam logic [7:0] PROTO_TEXT [PROTO_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50,
                                                      8'h2F, 8'h30, 8'h2E, 8'h30};

    typedef struct packed {
        logic [2:0]  verdict;
        logic [3:0]  major;
        logic [3:0]  minor;
        logic [15:0] count;
    } t_head_verdict;

    typedef struct packed {
        logic [1:0]    act;
        logic [7:0]    b;
        bit            typed;
        t_head_verdict want;
    } t_probe_row;

    localparam t_head_verdict NO_VERDICT = '0;
    localparam int N_PROBES = 24;
    localparam t_probe_row PROBES [N_PROBES] = '{
        '{ACT_BYTE,    8'h00, 1'b1, '{V_BAD, 4'd0, 4'd0, 16'd0}},     // null byte
        '{ACT_TIMEOUT, 8'hFF, 1'b0, NO_VERDICT},                      // ignored after verdict
        '{ACT_CLOSE,   8'h00, 1'b0, NO_VERDICT},
        '{ACT_START,   8'hFF, 1'b0, NO_VERDICT},
        '{ACT_TIMEOUT, 8'h00, 1'b1, '{V_TIMEOUT, 4'd0, 4'd0, 16'd0}},
        '{ACT_START,   8'h00, 1'b0, NO_VERDICT},
        '{ACT_CLOSE,   8'hFF, 1'b1, '{V_BAD, 4'd0, 4'd0, 16'd0}},
        '{ACT_START,   8'h5A, 1'b0, NO_VERDICT},
        // "A <FF> HTTP/9.9" CRLF CRLF
        '{ACT_BYTE,    8'h41, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    CH_SP, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'hFF, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    CH_SP, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h48, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h54, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h54, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h50, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h2F, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h39, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h2E, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    8'h39, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    CH_CR, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    CH_LF, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    CH_CR, 1'b0, NO_VERDICT},
        '{ACT_BYTE,    CH_LF, 1'b1, '{V_OK, 4'd9, 4'd9, 16'd0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    hrhc_in_if  req_if ();
    hrhc_out_if res_if ();

    http_request_head_checker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state mirrored from the word stream
    logic [15:0] lim_req_line, lim_hdr_line, lim_hdr_cnt;
    logic [1:0]  p_phase, p_part;
    int          p_len;
    bit          p_cr, p_bad, p_name_seen, p_uri_seen, p_colon;
    int          p_vpos;
    logic [3:0]  p_major, p_minor;
    logic [15:0] p_hdrs;

    t_head_verdict pending_verdicts [$];
    logic [7:0]    head_bytes [$];
    logic [7:0]    token_set [$];

    bit            word_typed;
    t_head_verdict word_want;
    bit            gaps_on = 1'b1;
    bit            stalls_on = 1'b1;
    bit            failed = 1'b0;
    int            words_sent = 0;
    int            stall_left = 0;
    int            idle_cycles = 0;

    function automatic bit is_dec_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit is_token_byte(logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                         8'h2D, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E};
    endfunction

    function automatic bit is_white(logic [7:0] b);
        return b inside {CH_SP, [8'h09:8'h0D]};
    endfunction

    function automatic void reset_line_state();
        p_part      = FP_METHOD;
        p_len       = 0;
        p_cr        = 1'b0;
        p_bad       = 1'b0;
        p_name_seen = 1'b0;
        p_uri_seen  = 1'b0;
        p_colon     = 1'b0;
    endfunction

    function automatic void restart_head();
        reset_line_state();
        p_phase = PH_REQ;
        p_vpos  = 0;
        p_major = 4'd0;
        p_minor = 4'd0;
        p_hdrs  = 16'd0;
    endfunction

    function automatic t_head_verdict close_head(logic [2:0] v);
        t_head_verdict r;
        r.verdict = v;
        r.major   = (v == V_OK) ? p_major : 4'd0;
        r.minor   = (v == V_OK) ? p_minor : 4'd0;
        r.count   = p_hdrs;
        p_phase   = PH_DONE;
        return r;
    endfunction

    function automatic void feed_content(logic [7:0] b);
        if (p_phase == PH_REQ) begin
            if (p_part == FP_METHOD) begin
                if (b == CH_SP) begin
                    if (!p_name_seen) p_bad = 1'b1;
                    p_part = FP_URI;
                end else begin
                    if (!is_token_byte(b)) p_bad = 1'b1;
                    p_name_seen = 1'b1;
                end
            end else if (p_part == FP_URI) begin
                if (b == CH_SP) begin
                    if (!p_uri_seen) p_bad = 1'b1;
                    p_part = FP_VERSION;
                end else begin
                    if (is_white(b)) p_bad = 1'b1;
                    p_uri_seen = 1'b1;
                end
            end else if (p_vpos >= PROTO_LEN) begin
                p_bad = 1'b1;
            end else begin
                if (p_vpos == MAJOR_POS || p_vpos == MINOR_POS) begin
                    if (!is_dec_digit(b)) p_bad = 1'b1;
                    else if (p_vpos == MAJOR_POS) p_major = b[3:0];
                    else p_minor = b[3:0];
                end else if (b != PROTO_TEXT[p_vpos]) begin
                    p_bad = 1'b1;
                end
                p_vpos++;
            end
        end else if (!p_colon) begin
            if (b == CH_COLON) begin
                if (!p_name_seen) p_bad = 1'b1;
                p_colon = 1'b1;
            end else begin
                if (!is_token_byte(b)) p_bad = 1'b1;
                p_name_seen = 1'b1;
            end
        end
    endfunction

    // Advances the parser by one word; returns 1 when the word yields a verdict.
    function automatic bit parse_word(input logic [1:0] act, input logic [7:0] b,
                                      output t_head_verdict r);
        int         limit;
        logic [2:0] over;
        r = NO_VERDICT;
        if (act == ACT_START) begin
            restart_head();
            return 1'b0;
        end
        if (p_phase == PH_DONE) return 1'b0;
        limit = (p_phase == PH_REQ) ? int'(lim_req_line) : int'(lim_hdr_line);
        over  = (p_phase == PH_REQ) ? V_URI : V_FIELDS;
        if (p_len >= limit) begin
            r = close_head(over);
            return 1'b1;
        end
        if (act == ACT_CLOSE) begin
            r = close_head(V_BAD);
            return 1'b1;
        end
        if (act == ACT_TIMEOUT) begin
            r = close_head(V_TIMEOUT);
            return 1'b1;
        end
        if (b == 8'h00) begin
            r = close_head(V_BAD);
            return 1'b1;
        end
        p_len++;
        if (p_cr && b == CH_LF) begin
            p_cr = 1'b0;
            if (p_phase == PH_REQ) begin
                if (p_bad || p_part != FP_VERSION || p_vpos != PROTO_LEN) begin
                    r = close_head(V_BAD);
                    return 1'b1;
                end
                p_phase = PH_HDR;
                reset_line_state();
                return 1'b0;
            end
            if (p_len == 2) begin
                r = close_head(V_OK);
                return 1'b1;
            end
            // header count limit beats a malformed line
            if (p_hdrs >= lim_hdr_cnt) begin
                r = close_head(V_FIELDS);
                return 1'b1;
            end
            if (p_bad || !p_colon) begin
                r = close_head(V_BAD);
                return 1'b1;
            end
            p_hdrs = p_hdrs + 16'd1;
            reset_line_state();
            return 1'b0;
        end
        // a CR not followed by LF is plain content
        if (p_cr) begin
            feed_content(CH_CR);
            p_cr = 1'b0;
        end
        if (b == CH_CR) p_cr = 1'b1;
        else feed_content(b);
        if (p_len >= limit) begin
            r = close_head(over);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        head_bytes.insert(head_bytes.size(), b);
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endfunction

    function automatic void push_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic logic [7:0] uri_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h21, 8'h7E));
        do b = 8'($urandom_range(1, 255)); while (is_white(b));
        return b;
    endfunction

    // Well-formed head with random method, URI, version and header lines.
    function automatic void build_head();
        int n;
        int m;
        head_bytes.delete();
        n = $urandom_range(1, 6);
        repeat (n) add_byte(token_set[$urandom_range(0, token_set.size() - 1)]);
        add_byte(CH_SP);
        n = $urandom_range(1, 10);
        repeat (n) add_byte(uri_byte());
        add_byte(CH_SP);
        push_text("HTTP/");
        add_byte(8'h30 + 8'($urandom_range(0, 9)));
        add_byte(8'h2E);
        add_byte(8'h30 + 8'($urandom_range(0, 9)));
        push_crlf();
        n = $urandom_range(0, 4);
        repeat (n) begin
            m = $urandom_range(1, 6);
            repeat (m) add_byte(token_set[$urandom_range(0, token_set.size() - 1)]);
            add_byte(CH_COLON);
            m = $urandom_range(0, 8);
            repeat (m) begin
                if ($urandom_range(0, 15) == 0) begin
                    add_byte(CH_CR);      // lone CR inside the value
                    add_byte(8'($urandom_range(8'h20, 8'h7E)));
                end else if ($urandom_range(0, 2) == 0) begin
                    add_byte(8'($urandom_range(1, 255)) | 8'h80);
                end else begin
                    add_byte(8'($urandom_range(8'h20, 8'h7E)));
                end
            end
            push_crlf();
        end
        push_crlf();
    endfunction

    task automatic send_word(input logic [1:0] act, input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.action    <= act;
        req_if.data_byte <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_head();
        for (int k = 0; k < head_bytes.size(); k++) begin
            if ($urandom_range(0, 299) == 0) send_word(ACT_START, 8'($urandom));
            send_word(ACT_BYTE, head_bytes[k]);
        end
    endtask

    task automatic send_request();
        int k;
        build_head();
        k = $urandom_range(0, head_bytes.size() - 1);
        case ($urandom_range(0, 14))
            0: head_bytes[k] = 8'($urandom);
            1: head_bytes[k] = 8'h00;
            2: head_bytes.delete(k);
            3: head_bytes.insert(k, 8'($urandom));
            4: while (head_bytes.size() > k) void'(head_bytes.pop_back());
            default: ;
        endcase
        if ($urandom_range(0, 19) != 0) send_word(ACT_START, 8'($urandom));
        send_head();
        case ($urandom_range(0, 7))
            0: send_word(ACT_CLOSE, 8'($urandom));
            1: send_word(ACT_TIMEOUT, 8'($urandom));
            2: repeat ($urandom_range(1, 3)) send_word(ACT_BYTE, 8'($urandom));
            default: ;
        endcase
    endtask

    task automatic run_requests(input int budget);
        int base;
        base = words_sent;
        while (words_sent - base < budget) send_request();
    endtask

    // Stop sending, let every pending verdict drain, then let the pipe empty.
    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] req_len, input logic [15:0] hdr_len,
                              input logic [15:0] hdr_cnt);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MAX_REQ_LINE;
        i_cfg_wdata <= req_len;
        @(posedge i_clk);
        lim_req_line = req_len;
        i_cfg_idx   <= CFG_MAX_HDR_LINE;
        i_cfg_wdata <= hdr_len;
        @(posedge i_clk);
        lim_hdr_line = hdr_len;
        i_cfg_idx   <= CFG_MAX_HDR_CNT;
        i_cfg_wdata <= hdr_cnt;
        @(posedge i_clk);
        lim_hdr_cnt = hdr_cnt;
        i_cfg_we    <= 1'b0;
    endtask

    // input side: predict at each accepted word
    always @(posedge i_clk) begin
        t_head_verdict got;
        bit has;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            has = parse_word(req_if.action, req_if.data_byte, got);
            if (word_typed) pending_verdicts.insert(pending_verdicts.size(), word_want);
            else if (has) pending_verdicts.insert(pending_verdicts.size(), got);
        end
    end

    // output side: compare each accepted verdict word with the oldest prediction
    always @(posedge i_clk) begin
        t_head_verdict want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict word: verdict %0d", res_if.verdict);
                failed = 1'b1;
            end else begin
                want = pending_verdicts.pop_front();
                if (res_if.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, res_if.verdict);
                    failed = 1'b1;
                end
                if (res_if.version_major !== want.major) begin
                    $error("version_major: expected %0d, got %0d",
                           want.major, res_if.version_major);
                    failed = 1'b1;
                end
                if (res_if.version_minor !== want.minor) begin
                    $error("version_minor: expected %0d, got %0d",
                           want.minor, res_if.version_minor);
                    failed = 1'b1;
                end
                if (res_if.header_count !== want.count) begin
                    $error("header_count: expected %0d, got %0d",
                           want.count, res_if.header_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 7);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("http_request_head_checker verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_MAX_REQ_LINE;
        i_cfg_wdata      <= 16'd0;
        req_if.valid     <= 1'b0;
        req_if.action    <= ACT_START;
        req_if.data_byte <= 8'h00;
        word_typed       <= 1'b0;
        word_want        <= NO_VERDICT;
        for (int v = 0; v < 256; v++) begin
            if (is_token_byte(8'(v))) token_set.insert(token_set.size(), 8'(v));
        end
        lim_req_line = CFG_RESET_VAL;
        lim_hdr_line = CFG_RESET_VAL;
        lim_hdr_cnt  = CFG_RESET_VAL;
        restart_head();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on reset limits
        for (int k = 0; k < N_PROBES; k++) begin
            word_typed <= PROBES[k].typed;
            word_want  <= PROBES[k].want;
            send_word(PROBES[k].act, PROBES[k].b);
        end
        word_typed <= 1'b0;
        wait_quiet();

        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_requests(340);
        wait_quiet();
        set_limits(16'd20, 16'd16, 16'd2);
        run_requests(320);
        wait_quiet();
        set_limits(16'd1, 16'd1, 16'd0);
        run_requests(60);
        wait_quiet();
        set_limits(16'd0, 16'd0, 16'd0);
        run_requests(20);

        // limits lowered under a line already in progress
        wait_quiet();
        set_limits(CFG_RESET_VAL, CFG_RESET_VAL, CFG_RESET_VAL);
        send_word(ACT_START, 8'h00);
        head_bytes.delete();
        push_text("GET /index");
        send_head();
        wait_quiet();
        set_limits(16'd4, CFG_RESET_VAL, CFG_RESET_VAL);
        send_word(ACT_TIMEOUT, 8'h00);
        send_word(ACT_START, 8'h00);
        head_bytes.delete();
        push_text("GET / HTTP/1.1");
        push_crlf();
        push_text("A:1");
        push_crlf();
        push_text("B:2");
        push_crlf();
        push_text("Host: ab");
        wait_quiet();
        set_limits(CFG_RESET_VAL, CFG_RESET_VAL, CFG_RESET_VAL);
        send_head();
        wait_quiet();
        set_limits(CFG_RESET_VAL, 16'd3, 16'd1);
        send_word(ACT_BYTE, 8'h63);
        send_word(ACT_START, 8'h00);
        head_bytes.delete();
        push_text("GET / HTTP/1.1");
        push_crlf();
        push_text("A:1");
        push_crlf();
        push_text("B:2");
        push_crlf();
        wait_quiet();
        set_limits(CFG_RESET_VAL, CFG_RESET_VAL, CFG_RESET_VAL);
        send_head();
        wait_quiet();
        set_limits(CFG_RESET_VAL, CFG_RESET_VAL, 16'd1);
        head_bytes.delete();
        push_text("C:3");
        push_crlf();
        send_head();

        repeat (3) begin
            wait_quiet();
            set_limits(16'($urandom_range(8, 48)), 16'($urandom_range(3, 40)),
                       16'($urandom_range(0, 4)));
            run_requests(250);
        end

        // last stretch at full rate
        wait_quiet();
        set_limits(CFG_RESET_VAL, CFG_RESET_VAL, CFG_RESET_VAL);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_requests(340);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (!failed && pending_verdicts.size() == 0) begin
            $display("http_request_head_checker verification clean");
        end else begin
            $display("http_request_head_checker verification failed");
        end
        $finish;
    end

endmodule
